// ===== rtl/core/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrt_pkg
// shared types and constants of the tree extend unit
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int unsigned MaxNodesDef  = 1024;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned HopW         = 10;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam logic [HopW-1:0] HopMax   = 10'd1023;

  localparam logic [CfgIdxW-1:0] RegObst0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegObst1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegObst2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegObst3  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStep   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRadius = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStart  = 3'd6;

  localparam logic [1:0] StatAdded    = 2'd0;
  localparam logic [1:0] StatObstacle = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch sample, clear scan state
    logic scan_rd;   // issue read for scan index
    logic scan_acc;  // accumulate read data (nearest pass)
    logic nb_acc;    // accumulate read data (parent pass)
    logic sq_start;
    logic dv_start;
    logic dv_sel_y;
    logic steer_x;
    logic steer_y;
    logic par_rd;
    logic commit;
    logic done;
  } rrt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic far;
    logic full;
    logic obst;
    logic sq_busy;
    logic dv_busy;
  } rrt_sts_t;

endpackage

// ===== rtl/core/rrt_tree_extend_unit.sv =====
// ----------------------------------------------------------------------------
// rrt_tree_extend_unit
// one extension step of a minimum hop tree of points
// ----------------------------------------------------------------------------
// a start scans all n nodes of the tree for the one nearest the sample; when
// the sample lies farther than step from it, a square root and two divides
// steer it; an obstacle hit or a full tree skips the parent scan, else the
// parent scan, parent read and commit follow; busy drops in the strobe cycle
// one sample at a time; start is taken only while busy is low
// the result strobe is a single cycle, the receiver cannot stall; reset makes
// node 0 the start point and the tree one node long
module rrt_tree_extend_unit #(
  parameter int unsigned MaxNodes  = rrt_pkg::MaxNodesDef,
  parameter int unsigned CoordBits = rrt_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [15:0]                  sample_x_i,
  input  logic [15:0]                  sample_y_i,
  input  logic                         cfg_we_i,
  input  logic [rrt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rrt_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         result_valid_o,
  output logic [1:0]                   status_o,
  output logic [9:0]                   node_index_o,
  output logic [9:0]                   parent_index_o,
  output logic [15:0]                  new_x_o,
  output logic [15:0]                  new_y_o,
  output logic [9:0]                   hop_count_o
);
  import rrt_pkg::*;

  rrt_cmd_t cmd;
  rrt_sts_t sts;

  rrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .valid_o(result_valid_o),
    .cmd_o(cmd), .sts_i(sts));

  rrt_datapath #(.MaxNodes(MaxNodes), .CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .sample_x_i, .sample_y_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .status_o, .node_index_o, .parent_index_o, .new_x_o, .new_y_o, .hop_count_o);
endmodule

// ===== rtl/core/rrt_ram.sv =====
// ----------------------------------------------------------------------------
// rrt_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module rrt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/rrt_sqrt.sv =====
// ----------------------------------------------------------------------------
// rrt_sqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module rrt_sqrt #(
  parameter int unsigned InW = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [InW-1:0]       val_i,
  output logic                 busy_o,
  output logic [InW/2:0]       root_o
);
  localparam int unsigned Steps = InW/2 + 1;
  localparam int unsigned VW    = 2*Steps;
  localparam int unsigned CntW  = $clog2(Steps+1);

  logic [VW-1:0]   rem_q, val_q;
  logic [Steps-1:0] res_q;
  logic [CntW-1:0] cnt_q;
  logic [VW-1:0]   trial;
  logic [VW-1:0]   rem_sh;

  assign rem_sh = {rem_q[VW-3:0], val_q[VW-1:VW-2]};
  assign trial  = {res_q[Steps-2:0], 2'b01} + {VW{1'b0}};
  assign busy_o = (cnt_q != '0);
  assign root_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(Steps);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      res_q <= '0;
      val_q <= VW'(val_i);
    end else if (busy_o) begin
      val_q <= {val_q[VW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial;
        res_q <= {res_q[Steps-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        res_q <= {res_q[Steps-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/core/rrt_div.sv =====
// ----------------------------------------------------------------------------
// rrt_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rrt_div #(
  parameter int unsigned NumW = 36,
  parameter int unsigned DenW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW+1);

  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW+1:0] rem_sh;

  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NumW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      if (rem_sh >= {2'b00, den_q}) begin
        rem_q <= (DenW+1)'(rem_sh - {2'b00, den_q});
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DenW:0];
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/core/rrt_datapath.sv =====
// ----------------------------------------------------------------------------
// rrt_datapath
// node stores, scan accumulators, steering arithmetic and obstacle test
// ----------------------------------------------------------------------------
module rrt_datapath #(
  parameter int unsigned MaxNodes  = rrt_pkg::MaxNodesDef,
  parameter int unsigned CoordBits = rrt_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrt_pkg::rrt_cmd_t           cmd_i,
  output rrt_pkg::rrt_sts_t           sts_o,
  input  logic [15:0]                 sample_x_i,
  input  logic [15:0]                 sample_y_i,
  input  logic                        cfg_we_i,
  input  logic [rrt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rrt_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [1:0]                  status_o,
  output logic [9:0]                  node_index_o,
  output logic [9:0]                  parent_index_o,
  output logic [15:0]                 new_x_o,
  output logic [15:0]                 new_y_o,
  output logic [9:0]                  hop_count_o
);
  import rrt_pkg::*;

  localparam int unsigned AW   = $clog2(MaxNodes);
  localparam int unsigned CntW = AW + 1;
  localparam int unsigned DW   = CoordBits;
  localparam int unsigned SqW  = 2*DW + 1;
  localparam int unsigned RtW  = SqW/2 + 1;
  localparam int unsigned NumW = DW + 16 + 2;
  localparam int unsigned DenW = RtW + 1;
  localparam logic [DW-1:0] CoordMax = {DW{1'b1}};

  // configuration
  logic [63:0] obst_q [4];
  logic [15:0] step_q, radius_q;
  logic [31:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) obst_q[k] <= 64'd65535;
      step_q   <= 16'd640;
      radius_q <= 16'd1280;
      start_q  <= 32'd629155200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegObst0:  obst_q[0] <= cfg_data_i;
        RegObst1:  obst_q[1] <= cfg_data_i;
        RegObst2:  obst_q[2] <= cfg_data_i;
        RegObst3:  obst_q[3] <= cfg_data_i;
        RegStep:   step_q    <= cfg_data_i[15:0];
        RegRadius: radius_q  <= cfg_data_i[15:0];
        RegStart:  start_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] root_x, root_y;
  assign root_x = DW'(start_q[15:0]);
  assign root_y = DW'(start_q[31:16]);

  // node count
  logic [CntW-1:0] count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1);
    end else if (cmd_i.commit) begin
      count_q <= count_q + 1'b1;
    end
  end

  // scan address, with delayed copy matching ram read latency
  logic [AW-1:0] scan_q, rd_idx_q;
  logic          rd_root_q;
  logic [DW-1:0] sx_q, sy_q, nx_q, ny_q;
  logic [AW-1:0] par_q;
  logic [AW-1:0] raddr;

  assign raddr = cmd_i.par_rd ? par_q : scan_q;
  assign sts_o.scan_last = (CntW'(scan_q) + 1'b1 >= count_q);
  assign sts_o.full = (count_q >= CntW'(MaxNodes));

  logic [DW-1:0]   rx, ry;
  logic [HopW-1:0] rhop;
  logic [DW-1:0]   mx, my;
  logic [HopW-1:0] mhop;
  logic            we;

  assign we = cmd_i.commit;

  rrt_ram #(.Width(DW), .Depth(MaxNodes)) u_x (
    .clk_i, .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(nx_q),
    .raddr_i(raddr), .rdata_o(mx));
  rrt_ram #(.Width(DW), .Depth(MaxNodes)) u_y (
    .clk_i, .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(ny_q),
    .raddr_i(raddr), .rdata_o(my));

  logic [HopW-1:0] new_hop;
  rrt_ram #(.Width(HopW), .Depth(MaxNodes)) u_hop (
    .clk_i, .we_i(we), .waddr_i(count_q[AW-1:0]), .wdata_i(new_hop),
    .raddr_i(raddr), .rdata_o(mhop));

  // node 0 follows the start register, never the ram
  assign rx   = rd_root_q ? root_x : mx;
  assign ry   = rd_root_q ? root_y : my;
  assign rhop = rd_root_q ? '0 : mhop;
  assign new_hop = (rhop >= HopMax) ? HopMax : rhop + 1'b1;

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= raddr;
    rd_root_q <= (raddr == '0);
  end

  // rewind on load and again for the parent scan once the nearest scan is over
  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.sq_start) begin
      scan_q <= '0;
    end else if (cmd_i.scan_rd) begin
      scan_q <= scan_q + 1'b1;
    end
  end

  // squared distance of read node to reference point
  logic [DW-1:0] refx, refy, adx, ady;
  logic [SqW-1:0] d2;
  assign refx = cmd_i.nb_acc ? nx_q : sx_q;
  assign refy = cmd_i.nb_acc ? ny_q : sy_q;
  assign adx  = (rx > refx) ? rx - refx : refx - rx;
  assign ady  = (ry > refy) ? ry - refy : refy - ry;
  assign d2   = SqW'(adx * adx) + SqW'(ady * ady);

  logic [SqW-1:0]  best_q;
  logic            first_q, found_q;
  logic [AW-1:0]   near_q;
  logic [HopW-1:0] bhop_q;
  logic [DW-1:0]   nearx_q, neary_q;
  logic [31:0]     r2, s2;
  assign r2 = radius_q * radius_q;
  assign s2 = step_q * step_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q    <= DW'(sample_x_i);
      sy_q    <= DW'(sample_y_i);
      first_q <= 1'b1;
      found_q <= 1'b0;
    end else if (cmd_i.scan_acc) begin
      first_q <= 1'b0;
      if (first_q || d2 < best_q) begin
        best_q  <= d2;
        near_q  <= rd_idx_q;
        nearx_q <= rx;
        neary_q <= ry;
      end
    end else if (cmd_i.nb_acc) begin
      if ((SqW+1)'(d2) <= (SqW+1)'(r2) && (!found_q || rhop < bhop_q)) begin
        found_q <= 1'b1;
        bhop_q  <= rhop;
        par_q   <= rd_idx_q;
      end
    end
    if (cmd_i.sq_start) par_q <= near_q;
  end

  assign sts_o.far = ((SqW+1)'(best_q) > (SqW+1)'(s2));

  // steering
  logic [RtW-1:0]  root;
  logic [DenW-1:0] span;
  logic [NumW-1:0] quo, num;
  logic [DW-1:0]   mag_x, mag_y, mag;
  logic            dsq_busy;
  logic            div_busy;

  rrt_sqrt #(.InW(SqW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(cmd_i.sq_start), .val_i(best_q),
    .busy_o(dsq_busy), .root_o(root));
  assign sts_o.sq_busy = dsq_busy;
  assign span = (root == '0) ? DenW'(1) : DenW'(root);

  assign mag_x = (sx_q >= nearx_q) ? sx_q - nearx_q : nearx_q - sx_q;
  assign mag_y = (sy_q >= neary_q) ? sy_q - neary_q : neary_q - sy_q;
  assign mag   = cmd_i.dv_sel_y ? mag_y : mag_x;

  // numerator 2*mag*step + span over 2*span
  logic [DW+16-1:0] prod_q;
  always_ff @(posedge clk_i) prod_q <= mag * step_q;
  assign num = {1'b0, prod_q, 1'b0} + NumW'(span);

  rrt_div #(.NumW(NumW), .DenW(DenW+1)) u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.dv_start), .num_i(num),
    .den_i({span, 1'b0}), .busy_o(div_busy), .quo_o(quo));
  assign sts_o.dv_busy = div_busy;

  function automatic logic [DW-1:0] steer(input logic [DW-1:0] o, input logic [DW-1:0] t,
                                          input logic [NumW-1:0] q);
    logic [NumW:0] r;
    r = (NumW+1)'(o) + (NumW+1)'(q);
    if (t >= o) return (r > (NumW+1)'(CoordMax)) ? CoordMax : r[DW-1:0];
    return (q > NumW'(o)) ? '0 : DW'(NumW'(o) - q);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nx_q <= DW'(sample_x_i);
      ny_q <= DW'(sample_y_i);
    end else if (cmd_i.steer_x) begin
      nx_q <= steer(nearx_q, sx_q, quo);
    end else if (cmd_i.steer_y) begin
      ny_q <= steer(neary_q, sy_q, quo);
    end
  end

  // obstacle test
  logic obst;
  always_comb begin
    logic [15:0] xl, yl, xh, yh, px, py;
    obst = 1'b0;
    px = 16'(nx_q);
    py = 16'(ny_q);
    for (int k = 0; k < 4; k++) begin
      xl = obst_q[k][15:0];
      yl = obst_q[k][31:16];
      xh = obst_q[k][47:32];
      yh = obst_q[k][63:48];
      if (xl <= xh && px >= xl && px <= xh && py >= yl && py <= yh) obst = 1'b1;
    end
  end
  assign sts_o.obst = obst;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      new_x_o <= 16'(nx_q);
      new_y_o <= 16'(ny_q);
      if (sts_o.full) begin
        status_o <= StatFull;
      end else begin
        status_o <= obst ? StatObstacle : StatAdded;
      end
      node_index_o   <= '0;
      parent_index_o <= '0;
      hop_count_o    <= '0;
    end else if (cmd_i.commit) begin
      new_x_o        <= 16'(nx_q);
      new_y_o        <= 16'(ny_q);
      status_o       <= StatAdded;
      node_index_o   <= 10'(count_q);
      parent_index_o <= 10'(par_q);
      hop_count_o    <= 10'(new_hop);
    end
  end
endmodule

// ===== rtl/core/rrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrt_ctrl
// sequencer for scans, root, divides and commit
// ----------------------------------------------------------------------------
module rrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              valid_o,
  output rrt_pkg::rrt_cmd_t cmd_o,
  input  rrt_pkg::rrt_sts_t sts_i
);
  import rrt_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StScan, StScanEnd, StSqrt, StSqWait, StMulX, StDivX, StMulY, StDivY,
    StDecide, StNb, StNbEnd, StParRd, StCommit, StOut
  } state_e;

  state_e state_q;

  // accumulate flags are registered, so they trail the read and meet its data
  logic acc_q, nb_q;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    cmd_o = '0;
    cmd_o.scan_acc = acc_q;
    cmd_o.nb_acc   = nb_q;
    unique case (state_q)
      StIdle:    cmd_o.load = start_i;
      StScan:    begin cmd_o.scan_rd = 1'b1; end
      StScanEnd: ;
      StSqrt:    cmd_o.sq_start = 1'b1;
      StSqWait:  ;
      StMulX:    cmd_o.dv_start = 1'b1;
      // the y product is loaded on the last x cycle
      StDivX:    begin
        cmd_o.steer_x  = !sts_i.dv_busy;
        cmd_o.dv_sel_y = !sts_i.dv_busy;
      end
      StMulY:    begin cmd_o.dv_start = 1'b1; cmd_o.dv_sel_y = 1'b1; end
      StDivY:    begin cmd_o.steer_y = !sts_i.dv_busy; cmd_o.dv_sel_y = 1'b1; end
      StDecide:  cmd_o.done = sts_i.full || sts_i.obst;
      StNb:      cmd_o.scan_rd = 1'b1;
      StNbEnd:   ;
      StParRd:   cmd_o.par_rd = 1'b1;
      StCommit:  cmd_o.commit = 1'b1;
      StOut:     ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_o <= 1'b0;
      acc_q   <= 1'b0;
      nb_q    <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      acc_q   <= (state_q == StScan);
      nb_q    <= (state_q == StNb);
      unique case (state_q)
        StIdle:    if (start_i) state_q <= StScan;
        StScan:    if (sts_i.scan_last) state_q <= StScanEnd;
        StScanEnd: state_q <= StSqrt;
        StSqrt:    state_q <= sts_i.far ? StSqWait : StDecide;
        StSqWait:  if (!sts_i.sq_busy) state_q <= StMulX;
        StMulX:    state_q <= StDivX;
        StDivX:    if (!sts_i.dv_busy) state_q <= StMulY;
        StMulY:    state_q <= StDivY;
        StDivY:    if (!sts_i.dv_busy) state_q <= StDecide;
        StDecide:  begin
          if (sts_i.full || sts_i.obst) begin
            state_q <= StOut;
          end else begin
            state_q <= StNb;
          end
        end
        StNb:      if (sts_i.scan_last) state_q <= StNbEnd;
        StNbEnd:   state_q <= StParRd;
        StParRd:   state_q <= StCommit;
        StCommit:  state_q <= StOut;
        StOut:     begin state_q <= StIdle; valid_o <= 1'b1; end
        default:   state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== rtl/core/rrt_checker.sv =====
// ----------------------------------------------------------------------------
// rrt_checker
// port level checks of the tree extend unit
// ----------------------------------------------------------------------------
module rrt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic [1:0] status_o,
  input logic [9:0] node_index_o,
  input logic [9:0] hop_count_o
);
  import rrt_pkg::*;

  a_no_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result without work");
  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("strobe held");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o != 2'd3) else $error("bad status");
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != StatAdded) |-> (node_index_o == '0 && hop_count_o == '0))
    else $error("rejected word carries node");
  // work only begins with a taken start
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !busy) else $error("busy without start");
endmodule

bind rrt_tree_extend_unit rrt_checker u_rrt_checker (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .status_o, .node_index_o,
  .hop_count_o);

// ===== bench/rrt_tree_extend_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rrt_tree_extend_unit_tb
// drives sample points into the tree extend unit and checks every result word
// against a local model of nearest search, steering, obstacle test and
// min-hop parent choice
// ----------------------------------------------------------------------------
module rrt_tree_extend_unit_tb;
  import rrt_pkg::*;

  localparam int unsigned NodeCap   = MaxNodesDef;
  localparam int unsigned QuietLimit = 40000;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
  } sample_t;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  node;
    logic [9:0]  parent;
    logic [15:0] x;
    logic [15:0] y;
    logic [9:0]  hop;
  } extend_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [15:0]         sample_x_i;
  logic [15:0]         sample_y_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                result_valid_o;
  logic [1:0]          status_o;
  logic [9:0]          node_index_o;
  logic [9:0]          parent_index_o;
  logic [15:0]         new_x_o;
  logic [15:0]         new_y_o;
  logic [9:0]          hop_count_o;

  rrt_tree_extend_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .sample_x_i, .sample_y_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .result_valid_o, .status_o,
    .node_index_o, .parent_index_o, .new_x_o, .new_y_o, .hop_count_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // local copy of the tree and registers
  logic [63:0] rect_q [4];
  logic [15:0] step_q;
  logic [15:0] radius_q;
  logic [15:0] tree_x [NodeCap];
  logic [15:0] tree_y [NodeCap];
  logic [9:0]  tree_par [NodeCap];
  logic [9:0]  tree_hop [NodeCap];
  int unsigned tree_size;

  sample_t pending_samples[$];
  extend_t expected_ext[$];
  int      idle_pct;
  int      errors;
  bit      taken;

  function automatic logic [63:0] sq_dist(logic [15:0] ax, ay, bx, by);
    logic [63:0] dx, dy;
    dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
    dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
    return dx * dx + dy * dy;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bits;
    res  = '0;
    bits = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + bits) begin
        v   = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] steer(logic [15:0] o, t, logic [63:0] span);
    logic [63:0] mag, q, r;
    mag = (t >= o) ? 64'(t - o) : 64'(o - t);
    q   = (2 * mag * 64'(step_q) + span) / (2 * span);
    if (t >= o) begin
      r = 64'(o) + q;
      return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
    end
    return (q > 64'(o)) ? 16'd0 : 16'(64'(o) - q);
  endfunction

  function automatic bit hits_obstacle(logic [15:0] x, y);
    for (int k = 0; k < 4; k++) begin
      if (rect_q[k][15:0] <= rect_q[k][47:32] &&
          x >= rect_q[k][15:0] && x <= rect_q[k][47:32] &&
          y >= rect_q[k][31:16] && y <= rect_q[k][63:48])
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic extend_t extend_tree(sample_t s);
    extend_t     e;
    logic [63:0] best, d, span, r2;
    int unsigned near, par;
    logic [9:0]  best_hop;
    bit          found;
    near = 0;
    best = '0;
    for (int unsigned i = 0; i < tree_size; i++) begin
      d = sq_dist(tree_x[i], tree_y[i], s.x, s.y);
      if (i == 0 || d < best) begin
        best = d;
        near = i;
      end
    end
    e = '{status: StatAdded, node: '0, parent: '0, x: s.x, y: s.y, hop: '0};
    if (best > 64'(step_q) * 64'(step_q)) begin
      span = isqrt(best);
      if (span == 0) span = 1;
      e.x = steer(tree_x[near], s.x, span);
      e.y = steer(tree_y[near], s.y, span);
    end
    if (tree_size >= NodeCap) begin
      e.status = StatFull;
    end else if (hits_obstacle(e.x, e.y)) begin
      e.status = StatObstacle;
    end else begin
      r2       = 64'(radius_q) * 64'(radius_q);
      par      = near;
      found    = 1'b0;
      best_hop = '0;
      for (int unsigned i = 0; i < tree_size; i++) begin
        if (sq_dist(tree_x[i], tree_y[i], e.x, e.y) <= r2) begin
          if (!found || tree_hop[i] < best_hop) begin
            found    = 1'b1;
            best_hop = tree_hop[i];
            par      = i;
          end
        end
      end
      tree_x[tree_size]   = e.x;
      tree_y[tree_size]   = e.y;
      tree_par[tree_size] = par[9:0];
      tree_hop[tree_size] = (tree_hop[par] >= HopMax) ? HopMax : tree_hop[par] + 10'd1;
      e.node   = tree_size[9:0];
      e.parent = par[9:0];
      e.hop    = tree_hop[tree_size];
      tree_size++;
    end
    return e;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h, want %h", field, got, want);
    errors++;
  endtask

  // driver: a word stays on the ports until taken
  always @(negedge clk_i) begin : drive
    sample_t s;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
        s = pending_samples.pop_front();
        sample_x_i <= s.x;
        sample_y_i <= s.y;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check result words, then predict for a taken sample
  int quiet;
  always @(posedge clk_i) begin : watch
    extend_t e;
    sample_t s;
    taken = 1'b0;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_ext.size() == 0) begin
          $display("unexpected result word");
          errors++;
        end else begin
          e = expected_ext.pop_front();
          if (status_o !== e.status) report("status", 16'(status_o), 16'(e.status));
          if (node_index_o !== e.node) report("node", 16'(node_index_o), 16'(e.node));
          if (parent_index_o !== e.parent)
            report("parent", 16'(parent_index_o), 16'(e.parent));
          if (new_x_o !== e.x) report("new_x", new_x_o, e.x);
          if (new_y_o !== e.y) report("new_y", new_y_o, e.y);
          if (hop_count_o !== e.hop) report("hop", 16'(hop_count_o), 16'(e.hop));
        end
      end
      if (start && !busy) begin
        taken = 1'b1;
        s.x = sample_x_i;
        s.y = sample_y_i;
        expected_ext = {expected_ext, extend_tree(s)};
      end
      if (taken || result_valid_o) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("rrt_tree_extend_unit_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      RegObst0, RegObst1, RegObst2, RegObst3: rect_q[idx] = data;
      RegStep:   step_q = data[15:0];
      RegRadius: radius_q = data[15:0];
      RegStart: begin
        tree_x[0]   = data[15:0];
        tree_y[0]   = data[31:16];
        tree_par[0] = '0;
        tree_hop[0] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !start && expected_ext.size() == 0 && !busy);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic add_sample(logic [15:0] x, y);
    sample_t s;
    s.x = x;
    s.y = y;
    pending_samples = {pending_samples, s};
  endtask

  function automatic logic [63:0] rand_rect();
    logic [15:0] xl, yl;
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return 64'hFFFF;
      default: begin
        xl = 16'($urandom);
        yl = 16'($urandom);
        return {yl + 16'($urandom_range(4000)), xl + 16'($urandom_range(4000)), yl, xl};
      end
    endcase
  endfunction

  task automatic random_samples(int count);
    int unsigned k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(2) == 0) begin
        add_sample(16'($urandom), 16'($urandom));
      end else begin
        // cluster near a stored node so the radius search has company
        k = $urandom_range(tree_size - 1);
        add_sample(tree_x[k] + 16'($urandom_range(3000)) - 16'd1500,
                   tree_y[k] + 16'($urandom_range(3000)) - 16'd1500);
      end
    end
  endtask

  initial begin
    errors     = 0;
    quiet      = 0;
    idle_pct   = 16;
    rst_ni     = 1'b0;
    start      = 1'b0;
    sample_x_i = '0;
    sample_y_i = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    for (int k = 0; k < 4; k++) rect_q[k] = 64'hFFFF;
    step_q      = 16'd640;
    radius_q    = 16'd1280;
    tree_x[0]   = 16'h2580;
    tree_y[0]   = 16'h2580;
    tree_par[0] = '0;
    tree_hop[0] = '0;
    tree_size   = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: corners steer, near points land as given
    add_sample(16'h0000, 16'h0000);
    add_sample(16'hFFFF, 16'hFFFF);
    add_sample(16'h0000, 16'hFFFF);
    add_sample(16'hFFFF, 16'h0000);
    add_sample(16'h2580, 16'h2580);
    add_sample(16'h2600, 16'h2500);
    drain();

    // no steering, obstacle with inclusive edges, one disabled rectangle
    write_reg(RegStep, 64'hFFFF);
    write_reg(RegRadius, 64'h0);
    write_reg(RegObst0, {16'h2000, 16'h2000, 16'h1000, 16'h1000});
    write_reg(RegObst1, {16'hFFFF, 16'h0000, 16'h0000, 16'h0001});
    write_reg(3'd7, 64'h0123);
    add_sample(16'h1000, 16'h1000);
    add_sample(16'h2000, 16'h2000);
    add_sample(16'h0FFF, 16'h1000);
    add_sample(16'h2001, 16'h2000);
    add_sample(16'h5000, 16'h5000);
    add_sample(16'h1800, 16'h2001);
    drain();

    // zero step keeps far candidates on the nearest node; wide radius
    write_reg(RegStep, 64'h0);
    write_reg(RegRadius, 64'hFFFF);
    write_reg(RegStart, {32'h0, 16'h8000, 16'h8000});
    add_sample(16'hFFFF, 16'hFFFF);
    add_sample(16'h8000, 16'h8000);
    add_sample(16'h1234, 16'hABCD);
    drain();
    write_reg(RegStep, 64'd300);
    write_reg(RegRadius, 64'd600);
    write_reg(RegObst0, 64'hFFFF);
    add_sample(16'h8100, 16'h8000);
    add_sample(16'h8000, 16'h8100);
    add_sample(16'h8080, 16'h8080);
    add_sample(16'h9000, 16'h7000);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 16 : (ph == 1) ? 62 : 0;
      for (int k = 0; k < 4; k++) write_reg(k[CfgIdxW-1:0], rand_rect());
      case (ph)
        0: write_reg(RegStep, 64'(16'($urandom_range(200, 3000))));
        1: write_reg(RegStep, 64'(16'($urandom)));
        default: write_reg(RegStep, 64'd1);
      endcase
      write_reg(RegRadius, 64'(16'($urandom_range(ph == 1 ? 65535 : 4000))));
      write_reg(RegStart, {$urandom, $urandom});
      random_samples(80);
      drain();
    end

    // wide step, then one rectangle over the whole plane
    for (int k = 0; k < 4; k++) write_reg(k[CfgIdxW-1:0], 64'hFFFF);
    write_reg(RegStep, 64'hFFFF);
    write_reg(RegRadius, 64'd2000);
    write_reg(RegObst2, {16'hFFFF, 16'hFFFF, 16'h0, 16'h0});
    add_sample(16'h0000, 16'h0000);
    add_sample(16'hFFFF, 16'hFFFF);
    add_sample(16'($urandom), 16'($urandom));
    drain();

    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("rrt_tree_extend_unit_tb OK");
    end else begin
      $display("rrt_tree_extend_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== rrt_tree_extend_unit.f =====
rtl/core/rrt_pkg.sv
rtl/core/rrt_ram.sv
rtl/core/rrt_sqrt.sv
rtl/core/rrt_div.sv
rtl/core/rrt_datapath.sv
rtl/core/rrt_ctrl.sv
rtl/core/rrt_tree_extend_unit.sv
rtl/core/rrt_checker.sv
bench/rrt_tree_extend_unit_tb.sv
